### rtl/ssr_pkg.sv
package ssr_pkg;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic REG_STREAM_THRESHOLD = 1'b0;
  localparam logic REG_INSERT_RRPV      = 1'b1;

  localparam logic [1:0] RRPV_MAX        = 2'd3;
  localparam logic [1:0] REUSE_MAX       = 2'd3;
  localparam logic [1:0] REUSE_RESET     = 2'd1;
  localparam logic [1:0] REUSE_PREDICT   = 2'd2;
  localparam logic [1:0] THRESH_RESET    = 2'd3;
  localparam logic [1:0] INSERT_RESET    = 2'd2;

  localparam int SET_IN_W  = 11;
  localparam int WAY_IN_W  = 4;
  localparam int PC_W      = 22;
  localparam int PADDR_W   = 38;
  localparam int BLK_W     = 32;
  localparam int BLK_LSB   = 6;
  localparam int SIG_SHIFT = 12;
  localparam int STEP_W    = 5;

  typedef enum logic [1:0] {
    F_IDLE,
    F_REDUCE,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_AGE,
    B_WRITE
  } back_state_t;

  typedef struct packed {
    logic [1:0] stream_threshold;
    logic [1:0] insert_rrpv;
  } ssr_cfg_t;

endpackage

### rtl/ssr_queue.sv
module ssr_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

### rtl/ssr_front.sv
module ssr_front import ssr_pkg::*; #(
  parameter int NUM_SETS    = 2048,
  parameter int SIG_ENTRIES = 1024,
  parameter int SET_W       = 11,
  parameter int SIG_W       = 10,
  parameter int ITEM_W      = 59
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clearing,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_op,
  input  logic [SET_IN_W-1:0]  in_set_index,
  input  logic [WAY_IN_W-1:0]  in_way_index,
  input  logic [PC_W-1:0]      in_pc,
  input  logic [PADDR_W-1:0]   in_paddr,
  input  logic                 in_hit,
  output logic                 q_push,
  output logic [ITEM_W-1:0]    q_wdata,
  input  logic                 q_full
);

  function automatic int red_steps(int n, int vmax);
    int s;
    s = 0;
    if ((n & (n - 1)) != 0) begin
      while ((n << s) <= vmax) s++;
    end
    return s;
  endfunction

  localparam int SET_STEPS = red_steps(NUM_SETS, (1 << SET_IN_W) - 1);
  localparam int SIG_STEPS = red_steps(SIG_ENTRIES, (1 << PC_W) - 1);
  localparam int NSTEP     = (SET_STEPS > SIG_STEPS) ? SET_STEPS : SIG_STEPS;

  front_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic                  op_r, hit_r;
  logic [SET_IN_W-1:0]   set_r, set_nxt;
  logic [WAY_IN_W-1:0]   way_r;
  logic [PC_W-1:0]       sig_r, sig_nxt;
  logic [BLK_W-1:0]      blk_r;
  logic                  accept;
  logic [31:0]           set_div, sig_div;

  assign in_full = (state_r != F_IDLE) || clearing;
  assign accept  = in_push && !in_full;
  assign q_wdata = {op_r, SET_W'(set_r), way_r, SIG_W'(sig_r), blk_r, hit_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    set_nxt   = set_r;
    sig_nxt   = sig_r;
    q_push    = 1'b0;
    set_div   = 32'(NUM_SETS) << cnt_r;
    sig_div   = 32'(SIG_ENTRIES) << cnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          set_nxt   = in_set_index;
          sig_nxt   = in_pc ^ (in_pc >> SIG_SHIFT);
          cnt_nxt   = STEP_W'(NSTEP - 1);
          state_nxt = (NSTEP == 0) ? F_PUSH : F_REDUCE;
        end
      end
      F_REDUCE: begin
        if ((32'(cnt_r) < SET_STEPS) && (32'(set_r) >= set_div))
          set_nxt = set_r - SET_IN_W'(set_div);
        if ((32'(cnt_r) < SIG_STEPS) && (32'(sig_r) >= sig_div))
          sig_nxt = sig_r - PC_W'(sig_div);
        if (cnt_r == '0) state_nxt = F_PUSH;
        else cnt_nxt = cnt_r - STEP_W'(1);
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    set_r <= set_nxt;
    sig_r <= sig_nxt;
    if (accept) begin
      op_r  <= in_op;
      way_r <= in_way_index;
      blk_r <= in_paddr[BLK_LSB +: BLK_W];
      hit_r <= in_hit;
    end
  end

endmodule

### rtl/ssr_back.sv
module ssr_back import ssr_pkg::*; #(
  parameter int NUM_SETS    = 2048,
  parameter int NUM_WAYS    = 16,
  parameter int SIG_ENTRIES = 1024,
  parameter int SET_W       = 11,
  parameter int SIG_W       = 10,
  parameter int ITEM_W      = 59
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ssr_cfg_t            cfg,
  output logic                clearing,
  input  logic [ITEM_W-1:0]   q_rdata,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [WAY_IN_W-1:0] out_victim_way
);

  localparam int ROW_W    = 2 * NUM_WAYS;
  localparam int SROW_W   = BLK_W + 4;
  localparam int CLR_N    = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
  localparam int CLR_W    = $clog2(CLR_N);

  back_state_t           state_r, state_nxt;
  logic [CLR_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic                  op_r, hit_r;
  logic [SET_W-1:0]      set_r;
  logic [WAY_IN_W-1:0]   way_r;
  logic [SIG_W-1:0]      sig_r;
  logic [BLK_W-1:0]      blk_r;
  logic [ROW_W-1:0]      set_row_r;
  logic [SROW_W-1:0]     sig_row_r;
  logic [1:0]            maxv_r;
  logic                  seq_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [WAY_IN_W-1:0]   out_way_r, out_way_nxt;

  logic [ROW_W-1:0]      set_mem [NUM_SETS];
  logic [SROW_W-1:0]     sig_mem [SIG_ENTRIES];

  logic                  set_we, sig_we;
  logic [SET_W-1:0]      set_wa;
  logic [SIG_W-1:0]      sig_wa;
  logic [ROW_W-1:0]      set_wd;
  logic [SROW_W-1:0]     sig_wd;

  logic [1:0]            maxv, lane, vv, reuse, stream, stream_new, reuse_new, nv;
  logic [BLK_W-1:0]      last_blk;
  logic                  way_ok, streaming, reuse_pred, load;
  logic [WAY_IN_W-1:0]   pick;

  assign clearing   = (state_r == B_CLEAR);
  assign out_empty  = !out_valid_r;
  assign out_victim_way = out_way_r;
  assign reuse      = sig_row_r[SROW_W-1 -: 2];
  assign last_blk   = sig_row_r[2 +: BLK_W];
  assign stream     = sig_row_r[1:0];
  assign way_ok     = (32'(way_r) < NUM_WAYS);

  always_comb begin
    maxv = 2'd0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (set_row_r[2*w +: 2] > maxv) maxv = set_row_r[2*w +: 2];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    q_pop         = 1'b0;
    set_we        = 1'b0;
    sig_we        = 1'b0;
    set_wa        = set_r;
    sig_wa        = sig_r;
    set_wd        = set_row_r;
    sig_wd        = sig_row_r;
    load          = 1'b0;
    pick          = '0;
    stream_new    = 2'd0;
    reuse_new     = reuse;
    streaming     = 1'b0;
    reuse_pred    = 1'b0;
    nv            = 2'd0;
    lane          = 2'd0;
    vv            = 2'd0;
    out_valid_nxt = out_valid_r && !out_pop;
    out_way_nxt   = out_way_r;
    unique case (state_r)
      B_CLEAR: begin
        set_we = (32'(clr_cnt_r) < NUM_SETS);
        sig_we = (32'(clr_cnt_r) < SIG_ENTRIES);
        set_wa = clr_cnt_r[SET_W-1:0];
        sig_wa = clr_cnt_r[SIG_W-1:0];
        set_wd = {NUM_WAYS{RRPV_MAX}};
        sig_wd = {REUSE_RESET, {BLK_W{1'b0}}, 2'd0};
        if (32'(clr_cnt_r) == CLR_N - 1) state_nxt = B_IDLE;
        else clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_READ;
        end
      end
      B_READ:  state_nxt = B_AGE;
      B_AGE:   state_nxt = B_WRITE;
      B_WRITE: begin
        if (op_r == OP_VICTIM) begin
          if (!out_valid_r || out_pop) begin
            for (int w = NUM_WAYS - 1; w >= 0; w--) begin
              lane = set_row_r[2*w +: 2];
              vv   = lane + (RRPV_MAX - maxv_r);
              set_wd[2*w +: 2] = vv;
              if (vv == RRPV_MAX) pick = WAY_IN_W'(w);
            end
            set_we        = 1'b1;
            load          = 1'b1;
            out_valid_nxt = 1'b1;
            out_way_nxt   = pick;
            state_nxt     = B_IDLE;
          end
        end else begin
          if (seq_r) stream_new = (stream < cfg.stream_threshold) ? stream + 2'd1 : stream;
          streaming  = (stream_new >= cfg.stream_threshold);
          reuse_pred = (reuse >= REUSE_PREDICT);
          if (hit_r) begin
            nv = 2'd0;
            if (reuse < REUSE_MAX) reuse_new = reuse + 2'd1;
          end else begin
            if (streaming) nv = RRPV_MAX;
            else if (reuse_pred) nv = 2'd0;
            else nv = cfg.insert_rrpv;
            if (!reuse_pred && reuse != 2'd0) reuse_new = reuse - 2'd1;
          end
          for (int w = 0; w < NUM_WAYS; w++) begin
            if (way_ok && (32'(way_r) == w)) set_wd[2*w +: 2] = nv;
          end
          set_we    = way_ok;
          sig_we    = 1'b1;
          sig_wd    = {reuse_new, blk_r, stream_new};
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_way_r <= out_way_nxt;
    if (q_pop) begin
      {op_r, set_r, way_r, sig_r, blk_r, hit_r} <= q_rdata;
    end
    if (state_r == B_AGE) begin
      maxv_r <= maxv;
      seq_r  <= (blk_r == last_blk + BLK_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (set_we) set_mem[set_wa] <= set_wd;
    set_row_r <= set_mem[set_r];
  end

  always_ff @(posedge clk) begin
    if (sig_we) sig_mem[sig_wa] <= sig_wd;
    sig_row_r <= sig_mem[sig_r];
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_pop))
    else $error("result slot overwritten");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_victim_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("victim result lost");

  a_write_only_in_update_or_clear: assert property (@(posedge clk) disable iff (!rst_n)
    sig_we |-> (clearing || (state_r == B_WRITE && op_r == OP_UPDATE)))
    else $error("signature row written outside update");

endmodule

### rtl/srrip_signature_stream_replacement.sv
// channel  ports                                           accepted when
// in       in_push, in_full, in_op..in_hit                 in_push && !in_full
// out      out_empty, out_pop, out_victim_way              out_pop && !out_empty
// cfg      cfg_we, cfg_index, cfg_wdata                    cfg_we
//
// In the back end a request passes through queue pop, table read, age/compare and write back,
// the read-modify-write of the set and signature tables.
// The front end accepts a request and pushes it to the queue, with reduction steps between
// when NUM_SETS or SIG_ENTRIES is not a power of two; it takes no new request until the push,
// and it overlaps with the back end through a 2-entry queue.
// After reset a clearing pass over max(NUM_SETS, SIG_ENTRIES) table rows runs with in_full high.
// A victim result waits in the output register; update items keep flowing until the next victim stalls in write back.
module srrip_signature_stream_replacement import ssr_pkg::*; #(
  parameter int NUM_SETS    = 2048,
  parameter int NUM_WAYS    = 16,
  parameter int SIG_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_op,
  input  logic [SET_IN_W-1:0] in_set_index,
  input  logic [WAY_IN_W-1:0] in_way_index,
  input  logic [PC_W-1:0]     in_pc,
  input  logic [PADDR_W-1:0]  in_paddr,
  input  logic                in_hit,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [WAY_IN_W-1:0] out_victim_way,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [1:0]          cfg_wdata
);

  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SIG_W  = $clog2(SIG_ENTRIES);
  localparam int ITEM_W = 2 + SET_W + WAY_IN_W + SIG_W + BLK_W;

  ssr_cfg_t            cfg_r;
  logic                clearing, q_push, q_full, q_pop, q_empty;
  logic [ITEM_W-1:0]   q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stream_threshold <= THRESH_RESET;
      cfg_r.insert_rrpv      <= INSERT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STREAM_THRESHOLD: cfg_r.stream_threshold <= cfg_wdata;
        REG_INSERT_RRPV:      cfg_r.insert_rrpv      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ssr_front #(
    .NUM_SETS(NUM_SETS), .SIG_ENTRIES(SIG_ENTRIES),
    .SET_W(SET_W), .SIG_W(SIG_W), .ITEM_W(ITEM_W)
  ) u_front (
    .clk, .rst_n, .clearing,
    .in_push, .in_full, .in_op, .in_set_index, .in_way_index, .in_pc, .in_paddr, .in_hit,
    .q_push, .q_wdata, .q_full
  );

  ssr_queue #(.W(ITEM_W)) u_queue (
    .clk, .rst_n,
    .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  ssr_back #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_ENTRIES(SIG_ENTRIES),
    .SET_W(SET_W), .SIG_W(SIG_W), .ITEM_W(ITEM_W)
  ) u_back (
    .clk, .rst_n, .cfg(cfg_r), .clearing,
    .q_rdata, .q_empty, .q_pop,
    .out_empty, .out_pop, .out_victim_way
  );

endmodule

### sim/srrip_signature_stream_replacement_tb.sv
module srrip_signature_stream_replacement_tb import ssr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = 2048;
  localparam int NWAYS = 16;
  localparam int NSIG  = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                op;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic [PC_W-1:0]     pc;
    logic [PADDR_W-1:0]  paddr;
    logic                hit;
  } access_t;

  typedef struct {
    access_t     req;
    logic        has_way;
    logic [3:0]  way;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_op = 1'b0;
  logic [SET_IN_W-1:0] in_set_index = '0;
  logic [WAY_IN_W-1:0] in_way_index = '0;
  logic [PC_W-1:0] in_pc = '0;
  logic [PADDR_W-1:0] in_paddr = '0;
  logic in_hit = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [WAY_IN_W-1:0] out_victim_way;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  srrip_signature_stream_replacement dut (.*);

  logic [1:0]  rrpv_mem [NSETS*NWAYS];
  logic [1:0]  reuse_mem [NSIG];
  logic [31:0] last_blk_mem [NSIG];
  logic [1:0]  stream_mem [NSIG];
  logic [1:0]  thresh_q;
  logic [1:0]  insert_q;

  logic [3:0] victim_q [$];
  logic [3:0] typed_q [$];
  logic       typed_valid_q [$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit timed_out = 0;

  function automatic logic [9:0] sig_hash(logic [PC_W-1:0] pc);
    return 10'(pc ^ (pc >> SIG_SHIFT));
  endfunction

  task automatic predict_access(access_t a);
    int base;
    int sig;
    logic [1:0] mx;
    logic [1:0] nv;
    logic [31:0] blk;
    logic found;
    logic [3:0] pick;
    logic strm;
    logic reuse;
    base = int'(a.set_index % NSETS) * NWAYS;
    if (a.op == OP_VICTIM) begin
      mx = 0;
      found = 0;
      pick = 0;
      for (int w = 0; w < NWAYS; w++) if (rrpv_mem[base+w] > mx) mx = rrpv_mem[base+w];
      for (int w = 0; w < NWAYS; w++) begin
        rrpv_mem[base+w] = rrpv_mem[base+w] + (RRPV_MAX - mx);
        if (!found && rrpv_mem[base+w] == RRPV_MAX) begin
          found = 1;
          pick = 4'(w);
        end
      end
      victim_q.push_back(pick);
    end else begin
      sig = sig_hash(a.pc);
      blk = a.paddr[BLK_LSB +: BLK_W];
      if (blk == last_blk_mem[sig] + 32'd1) begin
        if (stream_mem[sig] < thresh_q) stream_mem[sig]++;
      end else begin
        stream_mem[sig] = 0;
      end
      last_blk_mem[sig] = blk;
      if (a.hit) begin
        if (a.way_index < NWAYS) rrpv_mem[base+a.way_index] = 0;
        if (reuse_mem[sig] < REUSE_MAX) reuse_mem[sig]++;
      end else begin
        strm = stream_mem[sig] >= thresh_q;
        reuse = reuse_mem[sig] >= REUSE_PREDICT;
        nv = strm ? RRPV_MAX : (reuse ? 2'd0 : insert_q);
        if (a.way_index < NWAYS) rrpv_mem[base+a.way_index] = nv;
        if (!reuse && reuse_mem[sig] > 0) reuse_mem[sig]--;
      end
    end
  endtask

  task automatic push_request(access_t a, logic has_way, logic [3:0] way);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    {in_op, in_set_index, in_way_index, in_pc, in_paddr, in_hit} <= a;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_access(a);
    if (a.op == OP_VICTIM) begin
      typed_q.push_back(way);
      typed_valid_q.push_back(has_way);
    end
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (victim_q.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STREAM_THRESHOLD) thresh_q = val;
    else insert_q = val;
    @(posedge clk);
  endtask

  function automatic access_t random_access(logic [PC_W-1:0] pc, logic [31:0] blk);
    access_t a;
    a.op = $urandom_range(99) < 40 ? OP_VICTIM : OP_UPDATE;
    a.set_index = $urandom_range(99) < 70 ? SET_IN_W'($urandom_range(7)) : SET_IN_W'($urandom);
    a.way_index = WAY_IN_W'($urandom);
    a.pc = pc;
    a.paddr = {blk, 6'($urandom)};
    a.hit = 1'($urandom_range(1));
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
      if (out_pop && !out_empty) begin
        idle_cycles <= 0;
        if (victim_q.size() == 0) begin
          $error("unexpected result victim_way=%0d", out_victim_way);
          errors++;
        end else begin
          if (out_victim_way !== victim_q[0]) begin
            $error("victim_way expected %0d actual %0d", victim_q[0], out_victim_way);
            errors++;
          end
          if (typed_valid_q[0] && out_victim_way !== typed_q[0]) begin
            $error("victim_way expected %0d actual %0d", typed_q[0], out_victim_way);
            errors++;
          end
          void'(victim_q.pop_front());
          void'(typed_q.pop_front());
          void'(typed_valid_q.pop_front());
        end
      end else if (in_push && !in_full) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  function automatic access_t mk(logic op, int set, int way, int pc, logic [37:0] pa, logic hit);
    access_t a;
    a.op = op;
    a.set_index = SET_IN_W'(set);
    a.way_index = WAY_IN_W'(way);
    a.pc = PC_W'(pc);
    a.paddr = pa;
    a.hit = hit;
    return a;
  endfunction

  initial begin
    stim_row_t rows [$];
    logic [PC_W-1:0] pcs [8];
    logic [31:0] blks [8];
    int k;
    access_t a;
    for (int i = 0; i < NSETS*NWAYS; i++) rrpv_mem[i] = RRPV_MAX;
    for (int i = 0; i < NSIG; i++) begin
      reuse_mem[i] = REUSE_RESET;
      last_blk_mem[i] = 0;
      stream_mem[i] = 0;
    end
    thresh_q = THRESH_RESET;
    insert_q = INSERT_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back('{mk(OP_VICTIM, 0, 0, 0, 0, 0), 1, 4'd0});
    rows.push_back('{mk(OP_VICTIM, 2047, 15, 22'h3FFFFF, '1, 1), 1, 4'd0});
    rows.push_back('{mk(OP_UPDATE, 5, 0, 22'h3FFFFF, 38'h40, 1), 0, 0});
    rows.push_back('{mk(OP_UPDATE, 5, 15, 22'h3FFFFF, 38'h80, 0), 0, 0});
    rows.push_back('{mk(OP_UPDATE, 5, 3, 22'h3FFFFF, 38'hC0, 0), 0, 0});
    rows.push_back('{mk(OP_UPDATE, 5, 4, 22'h3FFFFF, 38'h100, 0), 0, 0});
    rows.push_back('{mk(OP_VICTIM, 5, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk(OP_UPDATE, 2047, 15, 0, '1, 0), 0, 0});
    rows.push_back('{mk(OP_UPDATE, 2047, 15, 0, 38'h0, 0), 0, 0});
    rows.push_back('{mk(OP_UPDATE, 2047, 7, 0, 38'h3F, 1), 0, 0});
    rows.push_back('{mk(OP_VICTIM, 2047, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk(OP_UPDATE, 1, 0, 22'h155555, 38'h2AAAAAAAAA, 1), 0, 0});
    rows.push_back('{mk(OP_UPDATE, 1, 1, 22'h2AAAAA, 38'h1555555555, 0), 0, 0});
    rows.push_back('{mk(OP_VICTIM, 1, 0, 0, 0, 0), 0, 0});
    foreach (rows[i]) push_request(rows[i].req, rows[i].has_way, rows[i].way);
    drain_results();

    write_reg(REG_STREAM_THRESHOLD, 2'd0);
    write_reg(REG_INSERT_RRPV, 2'd3);
    for (int i = 0; i < 4; i++)
      push_request(mk(OP_UPDATE, 9, i, 22'h123, 38'(i) << 6, 0), 0, 0);
    push_request(mk(OP_VICTIM, 9, 0, 0, 0, 0), 0, 0);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 20; recv_idle_pct = 62; end
        2: begin send_idle_pct = 62; recv_idle_pct = 20; end
        4: begin send_idle_pct = 0; recv_idle_pct = 0; end
        default: ;
      endcase
      write_reg(REG_STREAM_THRESHOLD, 2'($urandom_range(3)));
      write_reg(REG_INSERT_RRPV, ph == 5 ? 2'd0 : 2'($urandom_range(3)));
      for (int i = 0; i < 8; i++) begin
        pcs[i] = PC_W'($urandom);
        blks[i] = $urandom;
      end
      for (int n = 0; n < 72; n++) begin
        k = $urandom_range(7);
        if ($urandom_range(99) < 75) blks[k] = blks[k] + 1;
        else blks[k] = $urandom;
        a = random_access(pcs[k], blks[k]);
        push_request(a, 0, 0);
        if (n == 36 && ph == 1) drain_results();
      end
      drain_results();
    end

    if (errors == 0 && victim_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### sim.f
rtl/ssr_pkg.sv
rtl/ssr_queue.sv
rtl/ssr_front.sv
rtl/ssr_back.sv
rtl/srrip_signature_stream_replacement.sv
sim/srrip_signature_stream_replacement_tb.sv
